// File: rtl/positional_sequence_editor_defines.svh
// Assertion macros shared by the positional sequence editor RTL.
`ifndef POSITIONAL_SEQUENCE_EDITOR_DEFINES_SVH
`define POSITIONAL_SEQUENCE_EDITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psed_pkg.sv
// Shared types and constants of the positional sequence editor.
package psed_pkg;

    // Field widths of the stream words
    localparam int POS_W       = 11;
    localparam int VAL_W       = 32;
    localparam int LEN_W       = 11;
    localparam int STAT_W      = 2;
    localparam int OP_W        = 3;
    localparam int TDATA_W     = 48;
    // Cell index width, covers the largest supported capacity
    localparam int TGT_W       = 12;
    // Read gather group size (lanes per first-level group)
    localparam int GRP         = 32;
    localparam int GRP_LO_W    = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic             shift_up;    // insert: cells above target take left neighbor
        logic             shift_down;  // remove: cells at/above target take right neighbor
        logic             load;        // append/change: cell at target takes value
        logic [TGT_W-1:0] target;
    } psed_cmd_t;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_GATHER
    } psed_state_t;

endpackage

// File: rtl/psed_cell.sv
// One storage cell of the sequence chain.
module psed_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  psed_pkg::psed_cmd_t   cmd,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [psed_pkg::TGT_W-1:0] MY_IDX = psed_pkg::TGT_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Select what this cell holds next
    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            if (MY_IDX == cmd.target)
                data_next = value;
            else if (MY_IDX > cmd.target)
                data_next = left;
        end
        else if (cmd.shift_down)
        begin
            if (MY_IDX >= cmd.target)
                data_next = right;
        end
        else if (cmd.load && (MY_IDX == cmd.target))
        begin
            data_next = value;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/psed_gather.sv
// Two-level registered read gather over the cell chain.
module psed_gather #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       capture,
    input  logic [psed_pkg::POS_W-1:0] pos,
    input  logic [DATA_WIDTH-1:0]      cells [CAPACITY],
    output logic [DATA_WIDTH-1:0]      word
);

    localparam int NGRP = (CAPACITY + psed_pkg::GRP - 1) / psed_pkg::GRP;
    localparam int HI_W = psed_pkg::POS_W - psed_pkg::GRP_LO_W;

    logic [psed_pkg::GRP_LO_W-1:0] pos_lo;
    logic [HI_W-1:0]               pos_hi;
    logic [HI_W-1:0]               hi_reg;
    logic [DATA_WIDTH-1:0]         grp_reg  [NGRP];
    logic [DATA_WIDTH-1:0]         grp_next [NGRP];

    assign pos_lo = pos[psed_pkg::GRP_LO_W-1:0];
    assign pos_hi = pos[psed_pkg::POS_W-1:psed_pkg::GRP_LO_W];

    // First level: lane select inside each group
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        localparam int BASE  = g * psed_pkg::GRP;
        localparam int LANES = ((CAPACITY - BASE) < psed_pkg::GRP) ?
                               (CAPACITY - BASE) : psed_pkg::GRP;

        always_comb
        begin
            grp_next[g] = '0;
            for (int j = 0; j < LANES; j++)
            begin
                if (int'(pos_lo) == j)
                    grp_next[g] = cells[BASE + j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (capture)
                grp_reg[g] <= grp_next[g];
        end
    end

    // Keep group index alongside the captured lanes
    always_ff @(posedge clk)
    begin
        if (capture)
            hi_reg <= pos_hi;
    end

    // Second level: group select
    always_comb
    begin
        word = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (int'(hi_reg) == g)
                word = grp_reg[g];
        end
    end

endmodule

// File: rtl/positional_sequence_editor.sv
// Positional sequence editor: ordered list of signed words in a shifting cell chain.
//
// Holds up to CAPACITY words of DATA_WIDTH bits in a row of cells. Each
// input word carries an operation (clear, append, insert at, remove at,
// change at, read at); each gives exactly one result word with the read
// value, found flag, status (done, store full, position out of range) and
// the new length. Insert and remove move every entry past the position in
// the same clock, since every cell loads from its neighbor in parallel.
// On accept the chain updates and the read lanes of each 32-entry group
// are captured; in the gather state the group is then selected into the
// output register once that register is free. A new word is accepted only
// after the previous one has left the gather stage. A result waiting on the
// output does not block acceptance of the next word; that word parks in the
// gather stage until the output register frees. No clearing pass after reset.
`include "positional_sequence_editor_defines.svh"

module positional_sequence_editor #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // operation[2:0], position[13:3], value[45:14], zero fill[47:46]
    input  logic [psed_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // read_value[31:0], found[32], status[34:33], length[45:35], zero fill[47:46]
    output logic [psed_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > psed_pkg::POS_W) ? CNT_W : psed_pkg::POS_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Input word fields
    logic [psed_pkg::OP_W-1:0]   in_op;
    logic [psed_pkg::POS_W-1:0]  in_pos;
    logic signed [psed_pkg::VAL_W-1:0] in_value;
    logic [DATA_WIDTH-1:0]       store_val;

    assign in_op    = s_axis_tdata[2:0];
    assign in_pos   = s_axis_tdata[13:3];
    assign in_value = s_axis_tdata[45:14];
    assign store_val = DATA_WIDTH'($unsigned(in_value));

    // Control state
    psed_pkg::psed_state_t state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   fire;
    logic                   out_free;
    logic                   out_load;

    // Pending result context
    logic                          is_read_reg;
    logic                          found_reg;
    logic [psed_pkg::STAT_W-1:0]   status_reg;
    logic [psed_pkg::LEN_W-1:0]    length_reg;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    logic [psed_pkg::TDATA_W-1:0]  m_data_reg;

    // Decode results
    psed_pkg::psed_cmd_t           dec_cmd;
    psed_pkg::psed_cmd_t           cmd;
    logic [psed_pkg::STAT_W-1:0]   dec_status;
    logic                          dec_found;
    logic                          dec_read;
    logic [CW-1:0]                 pos_ext;
    logic [CW-1:0]                 cnt_ext;
    logic                          is_full;

    // Chain wiring
    logic [DATA_WIDTH-1:0]         cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]         gather_word;
    logic [psed_pkg::VAL_W-1:0]    rd32;
    logic [psed_pkg::VAL_W-1:0]    result_value;

    assign fire     = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign pos_ext  = CW'(in_pos);
    assign cnt_ext  = CW'(count_reg);
    assign is_full  = (count_reg == CNT_FULL);

    // Operation decode, range checks ahead of full checks
    always_comb
    begin
        dec_cmd    = '0;
        dec_status = psed_pkg::STAT_DONE;
        dec_found  = 1'b0;
        dec_read   = 1'b0;
        count_next = count_reg;
        case (in_op)
            psed_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            psed_pkg::OP_APPEND:
            begin
                if (is_full)
                    dec_status = psed_pkg::STAT_FULL;
                else
                begin
                    dec_cmd.load   = 1'b1;
                    dec_cmd.target = psed_pkg::TGT_W'(count_reg);
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            psed_pkg::OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    dec_status = psed_pkg::STAT_RANGE;
                else if (is_full)
                    dec_status = psed_pkg::STAT_FULL;
                else
                begin
                    dec_cmd.shift_up = 1'b1;
                    dec_cmd.target   = psed_pkg::TGT_W'(in_pos);
                    count_next       = count_reg + CNT_W'(1);
                end
            end
            psed_pkg::OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                    dec_status = psed_pkg::STAT_RANGE;
                else
                begin
                    dec_cmd.shift_down = 1'b1;
                    dec_cmd.target     = psed_pkg::TGT_W'(in_pos);
                    count_next         = count_reg - CNT_W'(1);
                end
            end
            psed_pkg::OP_CHANGE:
            begin
                if (pos_ext >= cnt_ext)
                    dec_status = psed_pkg::STAT_RANGE;
                else
                begin
                    dec_cmd.load   = 1'b1;
                    dec_cmd.target = psed_pkg::TGT_W'(in_pos);
                end
            end
            psed_pkg::OP_READ:
            begin
                dec_read  = 1'b1;
                dec_found = (pos_ext < cnt_ext);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Cells act only on an accepted word
    assign cmd = fire ? dec_cmd : '0;

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        psed_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .value (store_val),
            .left  (left_w),
            .right (right_w),
            .data  (cell_data[i])
        );
    end

    // Read gather, captured in the accept cycle before the chain moves
    psed_gather #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gather (
        .clk     (clk),
        .capture (fire),
        .pos     (in_pos),
        .cells   (cell_data),
        .word    (gather_word)
    );

    // Stored width to 32-bit result field
    if (DATA_WIDTH >= psed_pkg::VAL_W)
    begin : g_rd_trunc
        assign rd32 = gather_word[psed_pkg::VAL_W-1:0];
    end
    else
    begin : g_rd_sext
        assign rd32 = psed_pkg::VAL_W'($signed(gather_word));
    end

    assign result_value = !is_read_reg ? '0 :
                          (found_reg ? rd32 : {psed_pkg::VAL_W{1'b1}});

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psed_pkg::S_IDLE:
            begin
                if (fire)
                    state_next = psed_pkg::S_GATHER;
            end
            psed_pkg::S_GATHER:
            begin
                if (out_free)
                    state_next = psed_pkg::S_IDLE;
            end
            default:
            begin
                state_next = psed_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            psed_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            psed_pkg::S_GATHER:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psed_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (fire)
                count_reg <= count_next;
        end
    end

    // Pending result context
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            is_read_reg <= dec_read;
            found_reg   <= dec_found;
            status_reg  <= dec_status;
            length_reg  <= psed_pkg::LEN_W'(count_next);
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= {2'b00, length_reg, status_reg, found_reg, result_value};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    `PSE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_FULL, "entry count above capacity")
    `PSE_ASSERT_NEXT(a_count_hold, !fire, $stable(count_reg), "count moved without accept")
    `PSE_ASSERT_NEXT(a_busy_after_accept, fire, !s_axis_tready, "ready while word in gather")
    `PSE_ASSERT_NEXT(a_load_valid, out_load, m_axis_tvalid, "result load lost valid")
    `PSE_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.shift_up, cmd.shift_down, cmd.load}), "cell command conflict")

endmodule

// File: test/tb_positional_sequence_editor.sv
// Self-checking testbench for the positional sequence editor stream block.
module tb_positional_sequence_editor;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;

    // Spare operation codes that the block must ignore
    localparam logic [psed_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [psed_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    // One edit command word
    typedef struct packed {
        logic [psed_pkg::OP_W-1:0]  op;
        logic [psed_pkg::POS_W-1:0] pos;
        logic [psed_pkg::VAL_W-1:0] value;
    } edit_t;

    // One result word
    typedef struct packed {
        logic [psed_pkg::VAL_W-1:0]  read_value;
        logic                        found;
        logic [psed_pkg::STAT_W-1:0] status;
        logic [psed_pkg::LEN_W-1:0]  length;
    } edit_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // operation[2:0], position[13:3], value[45:14], zero fill[47:46]
    logic [psed_pkg::TDATA_W-1:0]  s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // read_value[31:0], found[32], status[34:33], length[45:35], zero fill[47:46]
    logic [psed_pkg::TDATA_W-1:0]  m_axis_tdata;

    edit_t        pending_edits[$];
    edit_result_t expected_results[$];

    // Shadow copy of the sequence
    logic [psed_pkg::VAL_W-1:0] seq_store[CAPACITY];
    int                         seq_count;

    int error_count;
    int src_idle_pct;
    int sink_stall_pct;

    positional_sequence_editor #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Apply one edit to the shadow sequence and work out its result
    task automatic predict_edit(input edit_t ed, output edit_result_t res);
        int i;
        int p;
        begin
            p = ed.pos;
            res.read_value = '0;
            res.found      = 1'b0;
            res.status     = psed_pkg::STAT_DONE;
            case (ed.op)
                psed_pkg::OP_CLEAR:
                begin
                    seq_count = 0;
                end
                psed_pkg::OP_APPEND:
                begin
                    if (seq_count >= CAPACITY)
                        res.status = psed_pkg::STAT_FULL;
                    else
                    begin
                        seq_store[seq_count] = ed.value;
                        seq_count++;
                    end
                end
                psed_pkg::OP_INSERT:
                begin
                    // range check wins over the full check
                    if (p > seq_count)
                        res.status = psed_pkg::STAT_RANGE;
                    else if (seq_count >= CAPACITY)
                        res.status = psed_pkg::STAT_FULL;
                    else
                    begin
                        for (i = seq_count; i > p; i--)
                            seq_store[i] = seq_store[i-1];
                        seq_store[p] = ed.value;
                        seq_count++;
                    end
                end
                psed_pkg::OP_REMOVE:
                begin
                    if (p >= seq_count)
                        res.status = psed_pkg::STAT_RANGE;
                    else
                    begin
                        for (i = p; i + 1 < seq_count; i++)
                            seq_store[i] = seq_store[i+1];
                        seq_count--;
                    end
                end
                psed_pkg::OP_CHANGE:
                begin
                    if (p >= seq_count)
                        res.status = psed_pkg::STAT_RANGE;
                    else
                        seq_store[p] = ed.value;
                end
                psed_pkg::OP_READ:
                begin
                    if (p < seq_count)
                    begin
                        res.read_value = seq_store[p];
                        res.found      = 1'b1;
                    end
                    else
                        res.read_value = '1;
                end
                default:
                begin
                    // spare codes leave everything alone
                end
            endcase
            res.length = seq_count[psed_pkg::LEN_W-1:0];
        end
    endtask

    // Predict an edit and hand it to the driver
    task automatic queue_edit(input logic [psed_pkg::OP_W-1:0] op, input int pos,
                              input logic [psed_pkg::VAL_W-1:0] value);
        edit_t        ed;
        edit_result_t res;
        begin
            ed.op    = op;
            ed.pos   = pos[psed_pkg::POS_W-1:0];
            ed.value = value;
            predict_edit(ed, res);
            pending_edits.push_back(ed);
            expected_results.push_back(res);
        end
    endtask

    // Random data word, with the extremes weighted in
    function automatic logic [psed_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Position: mostly in range, some at the boundaries, some anywhere
    function automatic int pick_position(input int len);
        int r;
        begin
            r = $urandom_range(99);
            if (r < 65)
                return (len > 0) ? $urandom_range(len - 1) : 0;
            else if (r < 75)
                return len;
            else if (r < 82)
                return (len > 0) ? len - 1 : 0;
            else
                return $urandom_range(CAPACITY);
        end
    endfunction

    // One random edit against the current shadow length
    task automatic queue_random_edit(input bit allow_clear);
        int r;
        logic [psed_pkg::OP_W-1:0] op;
        begin
            r = $urandom_range(99);
            if (r < 3)
                op = allow_clear ? psed_pkg::OP_CLEAR : psed_pkg::OP_READ;
            else if (r < 24)
                op = psed_pkg::OP_APPEND;
            else if (r < 44)
                op = psed_pkg::OP_INSERT;
            else if (r < 62)
                op = psed_pkg::OP_REMOVE;
            else if (r < 76)
                op = psed_pkg::OP_CHANGE;
            else
                op = psed_pkg::OP_READ;
            queue_edit(op, pick_position(seq_count), pick_value());
        end
    endtask

    // Wait until every queued word has been sent and answered
    task automatic drain();
        begin
            while (pending_edits.size() != 0 || expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Driver: present the next pending word when the slot is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_edits.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                edit_t ed;
                ed = pending_edits.pop_front();
                s_axis_tdata  <= {2'b00, ed.value, ed.pos, ed.op};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: random backpressure and field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                edit_result_t got;
                edit_result_t exp;
                got.read_value = m_axis_tdata[31:0];
                got.found      = m_axis_tdata[32];
                got.status     = m_axis_tdata[34:33];
                got.length     = m_axis_tdata[45:35];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (got.read_value !== exp.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, exp.read_value, got.read_value);
                        error_count++;
                    end
                    if (got.found !== exp.found)
                    begin
                        $display("%0t: found expected %b actual %b",
                                 $time, exp.found, got.found);
                        error_count++;
                    end
                    if (got.status !== exp.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp.status, got.status);
                        error_count++;
                    end
                    if (got.length !== exp.length)
                    begin
                        $display("%0t: length expected %0d actual %0d",
                                 $time, exp.length, got.length);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int n;
        int r;
        error_count    = 0;
        seq_count      = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        rst_n          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, extremes, every operation, refusals
        queue_edit(psed_pkg::OP_READ,   0,        32'h1111_1111);
        queue_edit(psed_pkg::OP_REMOVE, 0,        '0);
        queue_edit(psed_pkg::OP_CHANGE, 0,        32'h2222_2222);
        queue_edit(psed_pkg::OP_INSERT, 1,        32'h3333_3333);
        queue_edit(psed_pkg::OP_INSERT, 0,        32'h7FFF_FFFF);
        queue_edit(psed_pkg::OP_APPEND, 0,        32'h8000_0000);
        queue_edit(psed_pkg::OP_APPEND, 2047,     '0);
        queue_edit(psed_pkg::OP_APPEND, 0,        '1);
        queue_edit(psed_pkg::OP_INSERT, 1,        32'h1234_5678);
        queue_edit(psed_pkg::OP_INSERT, 5,        32'h5555_AAAA);
        queue_edit(psed_pkg::OP_INSERT, 7,        32'h0BAD_0BAD);
        queue_edit(psed_pkg::OP_READ,   1,        '0);
        queue_edit(psed_pkg::OP_READ,   5,        '0);
        queue_edit(psed_pkg::OP_READ,   CAPACITY, '0);
        queue_edit(psed_pkg::OP_CHANGE, 2,        32'hAAAA_AAAA);
        queue_edit(psed_pkg::OP_REMOVE, 0,        '0);
        queue_edit(psed_pkg::OP_REMOVE, 4,        '0);
        queue_edit(psed_pkg::OP_CHANGE, 4,        32'hDEAD_BEEF);
        queue_edit(psed_pkg::OP_READ,   1,        '0);
        queue_edit(OP_SPARE_LO,         1,        32'hFFFF_0000);
        queue_edit(OP_SPARE_HI,         1,        32'h0000_FFFF);
        queue_edit(psed_pkg::OP_CLEAR,  3,        '1);
        queue_edit(psed_pkg::OP_READ,   0,        '0);

        // Fill to capacity with appends and inserts at random places, with occasional reads, changes and removes
        while (seq_count < CAPACITY)
        begin
            r = $urandom_range(99);
            if (r < 50 || seq_count == 0)
                queue_edit(psed_pkg::OP_APPEND, 0, pick_value());
            else if (r < 96)
                queue_edit(psed_pkg::OP_INSERT, $urandom_range(seq_count), pick_value());
            else if (r < 98)
                queue_edit(psed_pkg::OP_READ, $urandom_range(seq_count - 1), '0);
            else if (r < 99)
                queue_edit(psed_pkg::OP_CHANGE, $urandom_range(seq_count - 1),
                           pick_value());
            else
                queue_edit(psed_pkg::OP_REMOVE, $urandom_range(seq_count - 1), '0);
        end

        // Work around the full boundary
        queue_edit(psed_pkg::OP_APPEND, 0,            pick_value());
        queue_edit(psed_pkg::OP_INSERT, 0,            pick_value());
        queue_edit(psed_pkg::OP_INSERT, CAPACITY,     pick_value());
        queue_edit(psed_pkg::OP_REMOVE, CAPACITY,     '0);
        queue_edit(psed_pkg::OP_READ,   CAPACITY - 1, '0);
        queue_edit(psed_pkg::OP_READ,   CAPACITY,     '0);
        for (n = 0; n < 20; n++)
            queue_random_edit(1'b0);
        drain();

        // Random phases with different idle patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 53;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 53;
                end
                default:
                begin
                    src_idle_pct   = 16;
                    sink_stall_pct = 16;
                end
            endcase
            queue_edit(psed_pkg::OP_CLEAR, 0, '0);
            for (n = 0; n < 15; n++)
                queue_random_edit(1'b1);
            drain();
        end

        // Let the pipeline settle before the verdict
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_positional_sequence_editor passed");
        else
            $display("tb_positional_sequence_editor failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_positional_sequence_editor failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/psed_pkg.sv
rtl/psed_cell.sv
rtl/psed_gather.sv
rtl/positional_sequence_editor.sv
test/tb_positional_sequence_editor.sv
